>>> rtl/core/gray_box_blur_binarize_assert.svh
// Assertion macros for the gray box blur binarize RTL, included by its top level.
// Depends on nothing; included inside module bodies that check their own logic.
`ifndef GRAY_BOX_BLUR_BINARIZE_ASSERT_SVH
`define GRAY_BOX_BLUR_BINARIZE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbb assertion failed");

// The expression must hold at every clock edge outside reset.
`define GBB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("gbb assertion failed");

`endif

>>> rtl/core/gbb_pkg.sv
// Package for the gray box blur binarize block: constants, codes and types.
// Depends on nothing; used by the top level, gbb_div and the testbench.
`default_nettype none

package gbb_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HALF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE    = 3'd4;

  // Register reset values.
  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [11:0] RST_IMAGE_HEIGHT  = 12'd480;
  localparam logic [1:0]  RST_KERNEL_HALF   = 2'd1;
  localparam logic [8:0]  RST_BIN_THRESHOLD = 9'd128;
  localparam logic        RST_COLOR_MODE    = 1'b1;

  // Luma weights 0.299 / 0.587 / 0.114 in Q0.16.
  localparam logic [16:0] WEIGHT_RED   = 17'd19595;
  localparam logic [16:0] WEIGHT_GREEN = 17'd38470;
  localparam logic [16:0] WEIGHT_BLUE  = 17'd7471;

  // Window sum of up to 7x7 samples of 255, and its divisor of up to 49.
  localparam int unsigned SUM_W = 14;
  localparam int unsigned DIV_W = 6;

  // Window areas and their reciprocals, ceil(2^20 / area). The rounding error
  // stays small enough that the product is the exact floor for every sum of
  // 8-bit samples over that area.
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 21;
  localparam logic [DIV_W-1:0]   AREA_3X3  = 6'd9;
  localparam logic [DIV_W-1:0]   AREA_5X5  = 6'd25;
  localparam logic [DIV_W-1:0]   AREA_7X7  = 6'd49;
  localparam logic [RECIP_W-1:0] RECIP_ONE = 21'd1048576;
  localparam logic [RECIP_W-1:0] RECIP_3X3 = 21'd116509;
  localparam logic [RECIP_W-1:0] RECIP_5X5 = 21'd41944;
  localparam logic [RECIP_W-1:0] RECIP_7X7 = 21'd21400;

  // Request from the sequencer to the mean divider.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/core/gray_box_blur_binarize.sv
// Top level of the gray box blur binarize block: sequencer, counters, output.
// Depends on gbb_pkg, gbb_line_mem, gbb_div and gray_box_blur_binarize_assert.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | red_i green_i blue_i is_flush_i
//  out     | output    | out_valid_o/out_stall_i | binary_pixel_o end_of_frame_o
//  cfg     | input     | cfg_we_i                | cfg_idx_i cfg_wdata_i
//
// A transaction that yields no pixel goes through the store and check states only.
// One that yields a pixel reads an n x n window, n = 2h+1 for interior pixels
// and 1 otherwise, in the steps store, check, one line store read per cycle,
// the last read data, the reciprocal divide and the output. Reset needs no
// clearing pass. The output register holds its pixel through a stall, and
// input is stalled until it has been taken.
`default_nettype none

module gray_box_blur_binarize #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_HALF  = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      red_i,
  input  wire logic [7:0]                      green_i,
  input  wire logic [7:0]                      blue_i,
  input  wire logic                            is_flush_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 binary_pixel_o,
  output logic                                 end_of_frame_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [gbb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gbb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import gbb_pkg::*;

  `include "gray_box_blur_binarize_assert.svh"

  localparam int unsigned SLOTS = 2 * MAX_HALF + 1;
  localparam int unsigned SLW   = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HALF + 1);
  localparam int unsigned RW    = 12;
  localparam int unsigned NW    = WW + RW + 2;
  localparam int unsigned DEPTH = SLOTS * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STORE = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // Configuration registers.
  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [1:0]  khalf_q;
  logic [8:0]  thr_q;
  logic        color_q;

  // Effective geometry.
  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [HW-1:0] eff_k;
  logic [NW-1:0] total, lag;
  logic [3:0]    side;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    eff_h = (height_q == '0) ? RW'(1) : height_q;
    if (32'(khalf_q) > MAX_HALF) begin
      eff_k = HW'(MAX_HALF);
    end else begin
      eff_k = HW'(khalf_q);
    end
  end

  assign total = NW'(eff_w * eff_h);
  assign lag   = NW'(eff_k * eff_w) + NW'(eff_k);
  assign side  = 4'({eff_k, 1'b1});

  // Sequencer and counter state.
  logic [2:0]     state_q, state_d;
  logic [7:0]     r_q, g_q, b_q;
  logic           flush_q;
  logic [CW-1:0]  in_col_q, in_col_d;
  logic [SLW-1:0] in_slot_q, in_slot_d;
  logic [NW-1:0]  n_q, n_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [RW-1:0]  out_row_q, out_row_d;
  logic [SLW-1:0] out_slot_q, out_slot_d;
  logic [NW-1:0]  o_q, o_d;
  logic [SLW-1:0] rs_q, rs_d;
  logic [CW-1:0]  cx_q, cx_d, cx0_q, cx0_d;
  logic [3:0]     dx_q, dx_d, dy_q, dy_d, span_q, span_d;
  logic           issue_q, issue_d, rd_vld_q, rd_vld_d, rd_last_q, rd_last_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic           out_valid_q, out_valid_d, bin_q, bin_d, eof_q, eof_d;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]     mem_rdata, gray;
  logic [24:0]    luma;
  div_req_t       div_req;
  logic           div_done;
  logic [7:0]     div_quo;
  logic           ready, interior;
  logic [SLW-1:0] win_slot;

  // Gray conversion of the held sample.
  assign luma = 25'(WEIGHT_RED * r_q) + 25'(WEIGHT_GREEN * g_q) + 25'(WEIGHT_BLUE * b_q);
  assign gray = color_q ? luma[23:16] : r_q;

  assign mem_waddr = AW'(in_slot_q * MAX_WIDTH) + AW'(in_col_q);
  assign mem_raddr = AW'(rs_q * MAX_WIDTH) + AW'(cx_q);

  // Output is due once its whole window has been written or the frame is in.
  assign ready = (o_q < total) && ((n_q >= total) || (n_q > o_q + lag));
  assign interior = (eff_k != '0) && (out_row_q >= RW'(eff_k))
                 && ((RW + 1)'(out_row_q) + (RW + 1)'(eff_k) < (RW + 1)'(eff_h))
                 && ((WW + 1)'(out_col_q) >= (WW + 1)'(eff_k))
                 && ((WW + 1)'(out_col_q) + (WW + 1)'(eff_k) < (WW + 1)'(eff_w));
  assign win_slot = (out_slot_q >= SLW'(eff_k)) ? out_slot_q - SLW'(eff_k)
                                                : out_slot_q + SLW'(SLOTS) - SLW'(eff_k);

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_slot_d   = in_slot_q;
    n_d         = n_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_slot_d  = out_slot_q;
    o_d         = o_q;
    rs_d        = rs_q;
    cx_d        = cx_q;
    cx0_d       = cx0_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    span_d      = span_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_last_d   = 1'b0;
    sum_d       = sum_q;
    dvs_d       = dvs_q;
    out_valid_d = out_valid_q;
    bin_d       = bin_q;
    eof_d       = eof_q;
    mem_we      = 1'b0;
    div_req     = '{start: 1'b0, dividend: sum_q + SUM_W'(mem_rdata), divisor: dvs_q};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        // Pixels past the end of the frame act as flushes.
        if (!flush_q && (n_q < total)) begin
          mem_we = 1'b1;
          n_d    = n_q + 1'b1;
          if ((WW + 1)'(in_col_q) + 1'b1 >= (WW + 1)'(eff_w)) begin
            in_col_d  = '0;
            in_slot_d = (in_slot_q == SLW'(SLOTS - 1)) ? '0 : in_slot_q + 1'b1;
          end else begin
            in_col_d = in_col_q + 1'b1;
          end
        end
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (ready) begin
          rs_d    = interior ? win_slot : out_slot_q;
          cx_d    = interior ? out_col_q - CW'(eff_k) : out_col_q;
          cx0_d   = cx_d;
          span_d  = interior ? side : 4'd1;
          dvs_d   = interior ? DIV_W'(side * side) : DIV_W'(1);
          dx_d    = '0;
          dy_d    = '0;
          sum_d   = '0;
          issue_d = 1'b1;
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        // One read issued per cycle, its data accumulated in the cycle after.
        if (issue_q) begin
          rd_vld_d = 1'b1;
          if (dx_q == span_q - 1'b1) begin
            dx_d = '0;
            cx_d = cx0_q;
            dy_d = dy_q + 1'b1;
            rs_d = (rs_q == SLW'(SLOTS - 1)) ? '0 : rs_q + 1'b1;
            if (dy_q == span_q - 1'b1) begin
              issue_d   = 1'b0;
              rd_last_d = 1'b1;
            end
          end else begin
            dx_d = dx_q + 1'b1;
            cx_d = cx_q + 1'b1;
          end
        end
        if (rd_vld_q) begin
          sum_d = sum_q + SUM_W'(mem_rdata);
          if (rd_last_q) begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          bin_d       = $signed({2'b00, div_quo}) > $signed({thr_q[8], thr_q});
          eof_d       = (o_q == total - 1'b1);
          out_valid_d = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = ST_IDLE;
          if (eof_q) begin
            in_col_d   = '0;
            in_slot_d  = '0;
            n_d        = '0;
            out_col_d  = '0;
            out_row_d  = '0;
            out_slot_d = '0;
            o_d        = '0;
          end else begin
            o_d = o_q + 1'b1;
            if ((WW + 1)'(out_col_q) + 1'b1 >= (WW + 1)'(eff_w)) begin
              out_col_d  = '0;
              out_row_d  = out_row_q + 1'b1;
              out_slot_d = (out_slot_q == SLW'(SLOTS - 1)) ? '0 : out_slot_q + 1'b1;
            end else begin
              out_col_d = out_col_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A register write aborts the frame in progress.
    if (cfg_we_i && (cfg_idx_i <= CFG_COLOR_MODE)) begin
      in_col_d   = '0;
      in_slot_d  = '0;
      n_d        = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      o_d        = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_slot_q   <= '0;
      n_q         <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      o_q         <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_slot_q   <= in_slot_d;
      n_q         <= n_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_slot_q  <= out_slot_d;
      o_q         <= o_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      r_q     <= red_i;
      g_q     <= green_i;
      b_q     <= blue_i;
      flush_q <= is_flush_i;
    end
    rs_q   <= rs_d;
    cx_q   <= cx_d;
    cx0_q  <= cx0_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    span_q <= span_d;
    sum_q  <= sum_d;
    dvs_q  <= dvs_d;
    bin_q  <= bin_d;
    eof_q  <= eof_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      khalf_q  <= RST_KERNEL_HALF;
      thr_q    <= RST_BIN_THRESHOLD;
      color_q  <= RST_COLOR_MODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i[10:0];
        CFG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i[11:0];
        CFG_KERNEL_HALF:   khalf_q  <= cfg_wdata_i[1:0];
        CFG_BIN_THRESHOLD: thr_q    <= cfg_wdata_i[8:0];
        CFG_COLOR_MODE:    color_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  gbb_line_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_line_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(gray),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  gbb_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign binary_pixel_o = bin_q;
  assign end_of_frame_o = eof_q;

  // A result waiting at the output always holds off new input.
  `GBB_ASSERT_IMPL(a_out_blocks_in, clk_i, rst_ni, out_valid_o, in_stall_o)
  // Emitted positions never overtake written positions.
  `GBB_ASSERT_ALWAYS(a_out_behind_in, clk_i, rst_ni, o_q <= n_q)
  // The divider only finishes while the sequencer waits for it.
  `GBB_ASSERT_IMPL(a_div_in_state, clk_i, rst_ni, div_done, state_q == ST_DIV)
  // Store reads only return while the window is being gathered.
  `GBB_ASSERT_IMPL(a_read_in_state, clk_i, rst_ni, rd_vld_q, state_q == ST_READ)

endmodule

`default_nettype wire

>>> rtl/core/gbb_line_mem.sv
// Gray line store: one write port, one read port, registered read data.
// Depends on nothing outside this file.
`default_nettype none

module gbb_line_mem #(
  parameter int unsigned DEPTH = 7168,
  parameter int unsigned AW    = 13
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/gbb_div.sv
// Window mean by reciprocal multiplication, result registered in the cycle after start.
// Depends on gbb_pkg for the operand widths, reciprocals and the request type.
`default_nettype none

module gbb_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gbb_pkg::div_req_t req_i,
  output logic                   done_o,
  output logic [7:0]             quotient_o
);
  import gbb_pkg::*;

  localparam int unsigned PW = SUM_W + RECIP_W;

  logic [RECIP_W-1:0] recip;
  logic [PW-1:0]      prod;
  logic [7:0]         quo_q, quo_d;
  logic               done_q, done_d;

  // Pick the reciprocal of the window area and scale the sum by it.
  always_comb begin
    case (req_i.divisor)
      AREA_3X3: recip = RECIP_3X3;
      AREA_5X5: recip = RECIP_5X5;
      AREA_7X7: recip = RECIP_7X7;
      default:  recip = RECIP_ONE;
    endcase
    prod   = PW'(req_i.dividend) * PW'(recip);
    quo_d  = req_i.start ? prod[RECIP_SHIFT +: 8] : quo_q;
    done_d = req_i.start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> tb/sv/gbb_checker.sv
`timescale 1ns / 1ps
// Checker for gray_box_blur_binarize: watches the input, output and register ports,
// predicts each output pixel and compares it. Depends on gbb_pkg for register indexes.
module gbb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  input  logic                            is_flush_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            binary_pixel_i,
  input  logic                            end_of_frame_i,
  input  logic                            cfg_we_i,
  input  logic [gbb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gbb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                              pixels_pending_o,
  output int                              mismatch_count_o
);
  import gbb_pkg::*;

  localparam int unsigned LINE_LEN = 1024;
  localparam int unsigned SLOTS    = 7;

  typedef struct packed {
    logic pixel;
    logic eof;
  } bin_pixel_t;

  // Shadow copy of the registers, counters and gray line store.
  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [1:0]  half_q;
  logic [8:0]  thresh_q;
  logic        colour_q;
  logic [7:0]  gray_lines [SLOTS*LINE_LEN];
  int unsigned in_col, in_row, out_col, out_row;
  bin_pixel_t  pixel_queue [$];

  assign pixels_pending_o = pixel_queue.size();

  task automatic report(input string what);
    if (mismatch_count_o < 50) $display("%0t mismatch: %s", $realtime, what);
    mismatch_count_o++;
  endtask

  function automatic logic [7:0] gray_at(input int unsigned row, input int unsigned col);
    return gray_lines[(row % SLOTS) * LINE_LEN + col];
  endfunction

  // Works out the binarised pixel that one input transaction releases, if any.
  task automatic predict_binarised(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic flush);
    int unsigned wd, ht, hk, total, n, o, val, sum, side;
    int unsigned gray;
    int          thr;
    bin_pixel_t  res;
    wd = (width_q == 0) ? 1 : ((width_q > LINE_LEN) ? LINE_LEN : width_q);
    ht = (height_q == 0) ? 1 : height_q;
    hk = half_q;
    total = wd * ht;
    thr = int'($signed(thresh_q));
    if (!flush && in_row < ht) begin
      gray = r;
      if (colour_q) gray = (19595 * r + 38470 * g + 7471 * b) >> 16;
      gray_lines[(in_row % SLOTS) * LINE_LEN + in_col] = gray[7:0];
      in_col++;
      if (in_col >= wd) begin
        in_col = 0;
        in_row++;
      end
    end
    n = in_row * wd + in_col;
    o = out_row * wd + out_col;
    if (o >= total) return;
    if (!(n >= total || n > o + hk * wd + hk)) return;
    if (hk > 0 && out_row >= hk && out_row + hk < ht && out_col >= hk && out_col + hk < wd)
    begin
      sum = 0;
      side = 2 * hk + 1;
      for (int unsigned y = out_row - hk; y <= out_row + hk; y++)
        for (int unsigned x = out_col - hk; x <= out_col + hk; x++)
          sum += gray_at(y, x);
      val = sum / (side * side);
    end else begin
      val = gray_at(out_row, out_col);
    end
    res.pixel = (int'(val) > thr);
    res.eof = (o == total - 1);
    pixel_queue = {pixel_queue, res};
    if (res.eof) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= wd) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // Register writes, input transactions and output transactions, seen at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    bin_pixel_t want;
    if (!rst_ni) begin
      width_q = RST_IMAGE_WIDTH;
      height_q = RST_IMAGE_HEIGHT;
      half_q = RST_KERNEL_HALF;
      thresh_q = RST_BIN_THRESHOLD;
      colour_q = RST_COLOR_MODE;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      pixel_queue.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:   width_q = cfg_wdata_i[10:0];
          CFG_IMAGE_HEIGHT:  height_q = cfg_wdata_i[11:0];
          CFG_KERNEL_HALF:   half_q = cfg_wdata_i[1:0];
          CFG_BIN_THRESHOLD: thresh_q = cfg_wdata_i[8:0];
          CFG_COLOR_MODE:    colour_q = cfg_wdata_i[0];
          default: ;
        endcase
        if (cfg_idx_i <= CFG_COLOR_MODE) begin
          in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_binarised(red_i, green_i, blue_i, is_flush_i);
      if (out_valid_i && !out_stall_i) begin
        if (pixel_queue.size() == 0) begin
          report("output pixel with none expected");
        end else begin
          want = pixel_queue.pop_front();
          if (binary_pixel_i !== want.pixel)
            report($sformatf("binary_pixel %b, expected %b", binary_pixel_i, want.pixel));
          if (end_of_frame_i !== want.eof)
            report($sformatf("end_of_frame %b, expected %b", end_of_frame_i, want.eof));
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the gray_box_blur_binarize testbench: clock, reset, frame stimulus and verdict.
// Depends on gbb_pkg, the block itself and gbb_checker.
module tb_top;
  import gbb_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            red_i = '0, green_i = '0, blue_i = '0;
  logic                  is_flush_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  binary_pixel_o, end_of_frame_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int                    pixels_pending, mismatch_count;
  int                    send_idle_pct = 0, recv_stall_pct = 0;
  int                    hold_cycles = 0;
  int                    items_sent = 0;

  gray_box_blur_binarize dut (.*);

  gbb_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .red_i, .green_i, .blue_i,
    .is_flush_i, .out_valid_i(out_valid_o), .out_stall_i, .binary_pixel_i(binary_pixel_o),
    .end_of_frame_i(end_of_frame_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pixels_pending_o(pixels_pending), .mismatch_count_o(mismatch_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: a long hold when asked, otherwise random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one transaction, with random idle cycles first, and waits until it is taken.
  task automatic send_item(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic flush);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    red_i = r; green_i = g; blue_i = b; is_flush_i = flush;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    items_sent++;
  endtask

  task automatic send_random_pixel();
    send_item($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b0);
  endtask

  // Waits until every expected pixel has arrived and the block has settled.
  task automatic drain();
    while (pixels_pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_frame(input int unsigned wd, input int unsigned ht, input int unsigned hk,
                           input int unsigned thr, input int unsigned colour);
    drain();
    write_reg(CFG_IMAGE_WIDTH, wd);
    write_reg(CFG_IMAGE_HEIGHT, ht);
    write_reg(CFG_KERNEL_HALF, hk);
    write_reg(CFG_BIN_THRESHOLD, thr);
    write_reg(CFG_COLOR_MODE, colour);
  endtask

  // Sends a frame of random pixels, then enough drain transactions (flushes, or
  // surplus pixels) to release every output pixel; or only a short part of it, undrained.
  task automatic run_frame(input int unsigned wd, input int unsigned ht, input int unsigned hk,
                           input int unsigned thr, input int unsigned colour,
                           input bit partial);
    int unsigned ew, eh, npix, ntail;
    set_frame(wd, ht, hk, thr, colour);
    ew = (wd == 0) ? 1 : ((wd > 1024) ? 1024 : wd);
    eh = (ht == 0) ? 1 : ht;
    npix = partial ? $urandom_range((ew * eh > 60) ? 59 : ew * eh - 1) : ew * eh;
    ntail = partial ? 0 : hk * ew + hk + $urandom_range(2);
    repeat (npix) send_random_pixel();
    repeat (ntail) begin
      if ($urandom_range(3) == 0) send_random_pixel();
      else send_item($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b1);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: flush with nothing ready, extremes of the samples, both modes.
    send_item(8'h00, 8'h00, 8'h00, 1'b1);
    set_frame(3, 3, 1, 9'h1FF, 1);
    send_item(8'h00, 8'h00, 8'h00, 1'b0);
    send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(8'hFF, 8'h00, 8'h00, 1'b0);
    send_item(8'h00, 8'hFF, 8'h00, 1'b0);
    send_item(8'h00, 8'h00, 8'hFF, 1'b0);
    send_item(8'hAA, 8'h55, 8'hAA, 1'b0);
    send_item(8'h55, 8'hAA, 8'h55, 1'b0);
    send_item(8'h01, 8'h80, 8'h7F, 1'b0);
    send_item(8'hFE, 8'h01, 8'h80, 1'b0);
    send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(8'h12, 8'h34, 8'h56, 1'b0);
    send_item(8'h00, 8'h00, 8'h00, 1'b1);
    set_frame(2, 2, 0, 255, 0);
    send_item(8'hFF, 8'h00, 8'h00, 1'b0);
    send_item(8'h00, 8'hFF, 8'hFF, 1'b0);
    send_item(8'h80, 8'h00, 8'h00, 1'b0);
    send_item(8'h7F, 8'h00, 8'h00, 1'b0);
    set_frame(3, 2, 0, 128, 0);
    send_item(8'hFE, 8'h00, 8'h00, 1'b0);
    send_item(8'h81, 8'h00, 8'h00, 1'b0);
    send_item(8'h80, 8'h00, 8'h00, 1'b0);

    // Register extremes, including values that clamp; the large frames are cut short.
    run_frame(0, 0, 3, 9'h100, 1, 0);
    run_frame(2047, 1, 3, 0, 1, 1);
    run_frame(7, 7, 3, 100, 1, 0);
    run_frame(1024, 2, 1, 127, 0, 1);
    run_frame(1, 4095, 0, 128, 1, 1);

    // Long receiver hold while the sender keeps offering pixels.
    hold_cycles = 400;
    run_frame(6, 5, 2, 90, 1, 0);

    // Random frames through the idling phases, some of them aborted part way.
    for (int unsigned f = 0; items_sent < 800; f++) begin
      case (f % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      run_frame($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(3),
                $urandom_range(511), $urandom_range(1), ($urandom_range(7) == 0));
    end

    drain();
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule

>>> gray_box_blur_binarize.f
+incdir+rtl/core
rtl/core/gbb_pkg.sv
rtl/core/gbb_line_mem.sv
rtl/core/gbb_div.sv
rtl/core/gray_box_blur_binarize.sv
tb/sv/gbb_checker.sv
tb/sv/tb_top.sv
